### hdl/indexed_list_insert_delete_assert.svh
// ----------------------------------------------------------------------------
// indexed list assertion macros
// concurrent check helpers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define ILD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ild_pkg.sv
// ----------------------------------------------------------------------------
// ild_pkg
// shared sizes, codes, beat types and helpers of the indexed list
// ----------------------------------------------------------------------------
package ild_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = 5;
  localparam int LEN_W = 5;
  localparam int IO_W  = 32;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [POS_W-1:0]       position;
    logic signed [IO_W-1:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [IO_W-1:0] data_out;
    logic [LEN_W-1:0]       length;
  } out_beat_t;

  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [CMP_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] wdata;
  } ctrl_t;

  function automatic logic [DATA_WIDTH-1:0] to_entry(logic [IO_W-1:0] v);
    logic [63:0] wide;
    wide = 64'($signed(v));
    return wide[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [IO_W-1:0] to_io(logic [DATA_WIDTH-1:0] v);
    logic [63:0] wide;
    wide = 64'($signed(v));
    return wide[IO_W-1:0];
  endfunction

endpackage

### hdl/ild_cell.sv
// ----------------------------------------------------------------------------
// ild_cell
// one list slot: holds, loads new data, or takes a neighbor's entry
// ----------------------------------------------------------------------------
module ild_cell (
  input  logic                          clk_i,
  input  ild_pkg::ctrl_t                ctrl_i,
  input  logic [ild_pkg::IDX_W-1:0]     idx_i,
  input  logic [ild_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [ild_pkg::DATA_WIDTH-1:0] right_i,
  output logic [ild_pkg::DATA_WIDTH-1:0] data_o
);
  import ild_pkg::*;

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic [CMP_W-1:0]      idx_x;

  assign idx_x = CMP_W'(idx_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (idx_x == ctrl_i.pos) begin
        entry_d = ctrl_i.wdata;
      end else if (idx_x > ctrl_i.pos) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (idx_x >= ctrl_i.pos) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;

endmodule

### hdl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// positional list with insert, delete and read by index
// ----------------------------------------------------------------------------
// Each beat is handled by a row of CAPACITY cells that shifts the entries at and
// above the position up or down by one slot in parallel, and a read picks the
// addressed slot, so a new beat is taken every cycle that the result register is
// free or drained. Every beat gives one registered result beat, in the cycle after
// it is taken, with status, read value and the entry count after the operation.
// Slot contents start undefined; only slots below the count are ever read.
module indexed_list_insert_delete (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ild_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ild_pkg::out_beat_t   out_data_o
);
  import ild_pkg::*;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q;
  out_beat_t             out_q, res;
  ctrl_t                 ctrl;
  logic                  accept, ins_ok, del_ok;
  logic [CMP_W-1:0]      pos_x, cnt_x;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_x      = CMP_W'(in_data_i.position);
  assign cnt_x      = CMP_W'(cnt_q);

  always_comb begin
    ins_ok       = 1'b0;
    del_ok       = 1'b0;
    res.status   = ST_DONE;
    res.data_out = '0;
    cnt_d        = cnt_q;
    case (in_data_i.opcode)
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          res.status = ST_RANGE;
        end else if (cnt_q == CNT_W'(CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_x >= cnt_x) begin
          res.status = ST_RANGE;
        end else begin
          del_ok = 1'b1;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          res.status = ST_RANGE;
        end else begin
          res.data_out = to_io(entries[pos_x[IDX_W-1:0]]);
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
    res.length = LEN_W'(cnt_d);
  end

  assign ctrl.ins   = accept && ins_ok;
  assign ctrl.del   = accept && del_ok;
  assign ctrl.pos   = pos_x;
  assign ctrl.wdata = to_entry(in_data_i.data_in);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ild_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .left_i  (entries[(g == 0) ? 0 : g - 1]),
      .right_i (entries[(g == CAPACITY - 1) ? g : g + 1]),
      .data_o  (entries[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "indexed_list_insert_delete_assert.svh"

`ILD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
`ILD_ASSERT_NEXT(a_ins_grow, ctrl.ins, cnt_q == $past(cnt_q) + CNT_W'(1), "insert did not grow list")
`ILD_ASSERT_NOW(a_len_match, out_valid_q, out_q.length == LEN_W'(cnt_q), "result length stale")
`ILD_ASSERT_NOW(a_err_zero, out_valid_q && (out_q.status != ST_DONE), out_q.data_out == '0, "error beat carries data")

endmodule

### dv/ild_list_checker.sv
// ----------------------------------------------------------------------------
// ild_list_checker
// watches both channels of the indexed list, keeps a shadow copy of the list,
// predicts the result of every accepted input beat and compares it field by
// field with the result beats in order
// ----------------------------------------------------------------------------
module ild_list_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  ild_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  ild_pkg::out_beat_t out_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import ild_pkg::*;

  logic signed [IO_W-1:0] shadow_list [CAPACITY];
  int                     shadow_len;
  out_beat_t              predicted_results [$];

  function automatic out_beat_t apply_list_op(in_beat_t beat);
    out_beat_t   res;
    int          pos;
    int          i;
    res.status   = ST_DONE;
    res.data_out = '0;
    pos          = int'(beat.position);
    case (beat.opcode)
      OP_INSERT: begin
        if (pos > shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = beat.data_in;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_READ: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.data_out = shadow_list[pos];
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(shadow_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      predicted_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result beat, expected none, got %p", $time, out_data_i);
        end else begin
          want = predicted_results.pop_front();
          if (out_data_i.status !== want.status) begin
            errors_o++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data_i.status);
          end
          if (out_data_i.data_out !== want.data_out) begin
            errors_o++;
            $display("%0t: data_out mismatch, expected %0d, got %0d",
                     $time, want.data_out, out_data_i.data_out);
          end
          if (out_data_i.length !== want.length) begin
            errors_o++;
            $display("%0t: length mismatch, expected %0d, got %0d",
                     $time, want.length, out_data_i.length);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_results.push_back(apply_list_op(in_data_i));
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the indexed list with a directed opening sequence and then random
// grow, shrink and mixed phases with noise, random gaps and stalls on both
// channels; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
  import ild_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 1130;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} list_mode_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;
  int        errors;
  int        pending;
  bit        quiet;
  int        fill_level;

  indexed_list_insert_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  ild_list_checker list_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= quiet || ($urandom_range(99) >= 16);
    end
  end

  initial begin
    #2_400_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_beat(input in_beat_t beat);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic issue_op(input logic [1:0] op, input int unsigned pos,
                          input logic [IO_W-1:0] data);
    in_beat_t beat;
    beat.opcode   = op;
    beat.position = POS_W'(pos);
    beat.data_in  = data;
    if (op == OP_INSERT && pos <= fill_level && fill_level < CAPACITY) fill_level++;
    else if (op == OP_DELETE && pos < fill_level) fill_level--;
    send_beat(beat);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [IO_W-1:0] pick_data();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op(input list_mode_e mode);
    int unsigned r;
    int unsigned ins_lim;
    int unsigned del_lim;
    logic [1:0]  op;
    int unsigned pos;
    r = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        ins_lim = 70;
        del_lim = 80;
      end
      MODE_SHRINK: begin
        ins_lim = 15;
        del_lim = 75;
      end
      default: begin
        ins_lim = 35;
        del_lim = 65;
      end
    endcase
    if (r >= 95) begin
      op  = 2'($urandom_range(3));
      pos = $urandom_range(31);
    end else if (r < ins_lim) begin
      op  = OP_INSERT;
      pos = $urandom_range(fill_level);
    end else begin
      op  = (r < del_lim) ? OP_DELETE : OP_READ;
      pos = (fill_level > 0) ? $urandom_range(fill_level - 1) : 0;
    end
    issue_op(op, pos, pick_data());
  endtask

  initial begin
    list_mode_e mode;
    int         sent;
    int         span;
    int         k;
    bit         first;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;
    fill_level = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty list corners
    issue_op(OP_READ, 0, 32'h1234_5678);
    issue_op(OP_DELETE, 0, 32'h0);
    issue_op(OP_INSERT, 1, 32'hdead_beef);
    // front, append and middle inserts with extreme values
    issue_op(OP_INSERT, 0, 32'h7fff_ffff);
    issue_op(OP_INSERT, 0, 32'h8000_0000);
    issue_op(OP_INSERT, 2, 32'hffff_ffff);
    issue_op(OP_INSERT, 1, 32'h0000_0000);
    issue_op(OP_UNUSED, 31, 32'hffff_ffff);
    issue_op(OP_READ, 0, 32'h0);
    issue_op(OP_READ, 3, 32'h0);
    issue_op(OP_READ, 4, 32'h0);
    issue_op(OP_READ, 31, 32'h0);
    issue_op(OP_INSERT, 31, 32'h5555_aaaa);
    issue_op(OP_DELETE, 1, 32'h0);
    issue_op(OP_DELETE, 2, 32'h0);
    issue_op(OP_DELETE, 3, 32'h0);
    issue_op(OP_DELETE, 0, 32'h0);
    // one entry left
    issue_op(OP_DELETE, 1, 32'h0);
    issue_op(OP_READ, 0, 32'h0);
    issue_op(OP_DELETE, 0, 32'h0);
    wait_drained();

    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      mode = first ? MODE_GROW : list_mode_e'($urandom_range(2));
      span = first ? 40 : $urandom_range(80, 20);
      for (k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        quiet = (sent >= 500 && sent < 700);
        random_op(mode);
        sent++;
      end
      if (first || $urandom_range(3) == 0) wait_drained();
      first = 1'b0;
    end
    quiet = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
